/* rtl/prl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prl_pkg
// Shared types and constants of the page replacement core.
// ----------------------------------------------------------------------------
package prl_pkg;

    localparam int ADDR_BITS_DEF  = 24;
    localparam int MAX_FRAMES_DEF = 512;

    localparam int SMALL_SHIFT = 13;
    localparam int LARGE_SHIFT = 14;
    localparam int STAMP_W     = 32;
    localparam int TALLY_W     = 32;
    localparam int FRAME_OUT_W = 9;
    localparam int EVPAGE_W    = 11;
    localparam int M_DATA_W    = 88;
    localparam int M_USER_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 3;
    localparam int MB_W        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LARGE_PAGES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_MB   = 2'd2;

    localparam logic [MB_W-1:0] MEMORY_MB_RESET = 3'd4;

    localparam logic POLICY_LRU = 1'b0;
    localparam logic POLICY_NRU = 1'b1;

    // Class above every real NRU class, so the first frame scanned always replaces it.
    localparam logic [2:0] CLASS_NONE = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_CLEAR,
        ST_PM_READ,
        ST_FR_READ,
        ST_HIT_CHECK,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_UPDATE
    } state_t;

endpackage

/* rtl/prl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module prl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/page_replacement_lru_nru_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_replacement_lru_nru_core
// Demand-paging page table with LRU or NRU victim selection.
// ----------------------------------------------------------------------------
// One transaction on the s_ channel is one memory access; each produces
// exactly one transaction on the m_ channel with the fault and eviction
// outcome and the running fault and writeback counts.
// The block handles one access at a time and deasserts s_tready while busy.
// Under NRU a remainder step of the access clock by the frame count comes
// first, and whenever that remainder is zero a sweep clears the referenced
// bits, one resident frame per cycle. A fault with all frames in use scans
// every frame through the frame RAM read port, one per cycle.
// The configuration channel is taken only while idle; a write to large_pages
// or memory_mb empties the page table at once, without a clearing pass.
// After reset no frame is resident and all counts are zero. A result waiting
// on a stalled m_ receiver is held; the next access may start meanwhile and
// waits at its final step until the earlier result has been taken.
// ----------------------------------------------------------------------------
module page_replacement_lru_nru_core #(
    parameter int ADDR_BITS  = prl_pkg::ADDR_BITS_DEF,
    parameter int MAX_FRAMES = prl_pkg::MAX_FRAMES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((ADDR_BITS+7)/8)*8-1:0]     s_tdata,   // address
    input  logic                               s_tuser,   // is_write
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // frame, evicted_page, fault_total, writeback_total, zero padding
    output logic [prl_pkg::M_DATA_W-1:0]       m_tdata,
    output logic [prl_pkg::M_USER_W-1:0]       m_tuser,   // fault, writeback, evicted_valid
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [prl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PAGE_W     = ADDR_BITS - prl_pkg::SMALL_SHIFT;
    localparam int PAGE_SLOTS = 1 << PAGE_W;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int FR_W       = PAGE_W + prl_pkg::STAMP_W + 1;
    localparam int BIT_W      = $clog2(prl_pkg::STAMP_W);
    localparam int PAD_W      = prl_pkg::M_DATA_W - prl_pkg::FRAME_OUT_W
                                - prl_pkg::EVPAGE_W - 2 * prl_pkg::TALLY_W;
    localparam logic [CNT_W:0] MAX_FRAMES_C = (CNT_W + 1)'(MAX_FRAMES);
    localparam logic [CNT_W+7:0] MAX_FRAMES_W = (CNT_W + 8)'(MAX_FRAMES);
    localparam logic [prl_pkg::TALLY_W-1:0] TALLY_MAX = '1;

    prl_pkg::state_t state_reg, state_next;

    logic                        policy_reg, policy_next;
    logic                        large_reg, large_next;
    logic [prl_pkg::MB_W-1:0]    mb_reg, mb_next;
    logic [CNT_W-1:0]            used_reg, used_next;
    logic [prl_pkg::STAMP_W-1:0] clock_reg, clock_next;
    logic [prl_pkg::TALLY_W-1:0] ftally_reg, ftally_next;
    logic [prl_pkg::TALLY_W-1:0] wtally_reg, wtally_next;

    logic [PAGE_W-1:0]           page_reg, page_next;
    logic                        wr_reg, wr_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic [CNT_W-1:0]            rem_reg, rem_next;
    logic [BIT_W-1:0]            bit_reg, bit_next;
    logic [FRAME_W-1:0]          idx_reg, idx_next;
    logic [FRAME_W-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic [2:0]                  best_class_reg, best_class_next;
    logic [prl_pkg::STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic [FRAME_W-1:0]          best_idx_reg, best_idx_next;
    logic [PAGE_W-1:0]           best_owner_reg, best_owner_next;
    logic                        best_dirty_reg, best_dirty_next;
    logic [FRAME_W-1:0]          frame_reg, frame_next;
    logic                        old_dirty_reg, old_dirty_next;
    logic                        fault_reg, fault_next;
    logic                        ev_reg, ev_next;
    logic                        wb_reg, wb_next;
    logic [PAGE_W-1:0]           evpage_reg, evpage_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        o_fault_reg, o_fault_next;
    logic                        o_wb_reg, o_wb_next;
    logic                        o_ev_reg, o_ev_next;
    logic [FRAME_W-1:0]          o_frame_reg, o_frame_next;
    logic [PAGE_W-1:0]           o_evpage_reg, o_evpage_next;

    logic [FRAME_W-1:0] pm_rdata;
    logic               pm_re, pm_we;
    logic [FR_W-1:0]    fr_rdata, fr_wdata;
    logic               fr_re, fr_we;
    logic [FRAME_W-1:0] fr_raddr;
    logic               ref_rdata, ref_we, ref_wdata;
    logic [FRAME_W-1:0] ref_waddr;

    logic [PAGE_W-1:0]           fr_owner;
    logic [prl_pkg::STAMP_W-1:0] fr_stamp;
    logic                        fr_dirty;

    logic [ADDR_BITS-1:0]  addr_in;
    logic [PAGE_W-1:0]     page_in;
    logic [prl_pkg::MB_W-1:0] mb_eff;
    logic [CNT_W+7:0]      n_raw;
    logic [CNT_W:0]        mod_t;
    logic [2:0]            cand_class;
    logic                  take;
    logic                  upd_go;
    logic                  hit;

    assign addr_in = s_tdata[ADDR_BITS-1:0];
    assign page_in = large_reg ? {1'b0, addr_in[ADDR_BITS-1:prl_pkg::LARGE_SHIFT]}
                               : addr_in[ADDR_BITS-1:prl_pkg::SMALL_SHIFT];
    assign mb_eff  = (mb_reg == '0) ? prl_pkg::MB_W'(1) : mb_reg;
    assign n_raw   = large_reg ? ((CNT_W + 8)'(mb_eff) << 6) : ((CNT_W + 8)'(mb_eff) << 7);

    assign {fr_dirty, fr_stamp, fr_owner} = fr_rdata;

    assign mod_t = {rem_reg, clock_reg[bit_reg]};
    assign cand_class = (policy_reg == prl_pkg::POLICY_NRU) ? {1'b0, ref_rdata, fr_dirty} : 3'd0;
    assign take = (cand_class < best_class_reg)
                  || ((cand_class == best_class_reg) && (fr_stamp < best_stamp_reg));
    assign hit = (CNT_W'(frame_reg) < used_reg) && (fr_owner == page_reg);
    assign upd_go = (state_reg == prl_pkg::ST_UPDATE) && (!out_valid_reg || m_tready);

    assign s_tready  = (state_reg == prl_pkg::ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == prl_pkg::ST_IDLE);

    assign pm_re    = (state_reg == prl_pkg::ST_PM_READ);
    assign pm_we    = upd_go;
    assign fr_re    = (state_reg == prl_pkg::ST_FR_READ) || (state_reg == prl_pkg::ST_SCAN);
    assign fr_raddr = (state_reg == prl_pkg::ST_FR_READ) ? pm_rdata : idx_reg;
    assign fr_we    = upd_go;
    assign fr_wdata = {wr_reg | (!fault_reg & old_dirty_reg), clock_reg, page_reg};
    assign ref_we    = upd_go || (state_reg == prl_pkg::ST_CLEAR);
    assign ref_wdata = upd_go;
    assign ref_waddr = upd_go ? frame_reg : idx_reg;

    prl_ram #(.WIDTH(FRAME_W), .DEPTH(PAGE_SLOTS)) u_page_map (
        .aclk(aclk), .we(pm_we), .waddr(page_reg), .wdata(frame_reg),
        .re(pm_re), .raddr(page_reg), .rdata(pm_rdata)
    );

    prl_ram #(.WIDTH(FR_W), .DEPTH(MAX_FRAMES)) u_frame_info (
        .aclk(aclk), .we(fr_we), .waddr(frame_reg), .wdata(fr_wdata),
        .re(fr_re), .raddr(fr_raddr), .rdata(fr_rdata)
    );

    prl_ram #(.WIDTH(1), .DEPTH(MAX_FRAMES)) u_frame_ref (
        .aclk(aclk), .we(ref_we), .waddr(ref_waddr), .wdata(ref_wdata),
        .re(fr_re), .raddr(idx_reg), .rdata(ref_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= prl_pkg::ST_IDLE;
            policy_reg    <= prl_pkg::POLICY_LRU;
            large_reg     <= 1'b0;
            mb_reg        <= prl_pkg::MEMORY_MB_RESET;
            used_reg      <= '0;
            clock_reg     <= '0;
            ftally_reg    <= '0;
            wtally_reg    <= '0;
            out_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            large_reg     <= large_next;
            mb_reg        <= mb_next;
            used_reg      <= used_next;
            clock_reg     <= clock_next;
            ftally_reg    <= ftally_next;
            wtally_reg    <= wtally_next;
            out_valid_reg <= out_valid_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg       <= page_next;
        wr_reg         <= wr_next;
        n_reg          <= n_next;
        rem_reg        <= rem_next;
        bit_reg        <= bit_next;
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_class_reg <= best_class_next;
        best_stamp_reg <= best_stamp_next;
        best_idx_reg   <= best_idx_next;
        best_owner_reg <= best_owner_next;
        best_dirty_reg <= best_dirty_next;
        frame_reg      <= frame_next;
        old_dirty_reg  <= old_dirty_next;
        fault_reg      <= fault_next;
        ev_reg         <= ev_next;
        wb_reg         <= wb_next;
        evpage_reg     <= evpage_next;
        o_fault_reg    <= o_fault_next;
        o_wb_reg       <= o_wb_next;
        o_ev_reg       <= o_ev_next;
        o_frame_reg    <= o_frame_next;
        o_evpage_reg   <= o_evpage_next;
    end

    always_comb begin
        state_next      = state_reg;
        policy_next     = policy_reg;
        large_next      = large_reg;
        mb_next         = mb_reg;
        used_next       = used_reg;
        clock_next      = clock_reg;
        ftally_next     = ftally_reg;
        wtally_next     = wtally_reg;
        page_next       = page_reg;
        wr_next         = wr_reg;
        n_next          = n_reg;
        rem_next        = rem_reg;
        bit_next        = bit_reg;
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        best_class_next = best_class_reg;
        best_stamp_next = best_stamp_reg;
        best_idx_next   = best_idx_reg;
        best_owner_next = best_owner_reg;
        best_dirty_next = best_dirty_reg;
        frame_next      = frame_reg;
        old_dirty_next  = old_dirty_reg;
        fault_next      = fault_reg;
        ev_next         = ev_reg;
        wb_next         = wb_reg;
        evpage_next     = evpage_reg;
        out_valid_next  = out_valid_reg;
        o_fault_next    = o_fault_reg;
        o_wb_next       = o_wb_reg;
        o_ev_next       = o_ev_reg;
        o_frame_next    = o_frame_reg;
        o_evpage_next   = o_evpage_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        // The shared compare stage of the victim scan.
        if (cmp_valid_reg && take) begin
            best_class_next = cand_class;
            best_stamp_next = fr_stamp;
            best_idx_next   = cmp_idx_reg;
            best_owner_next = fr_owner;
            best_dirty_next = fr_dirty;
        end

        case (state_reg)
            prl_pkg::ST_IDLE: begin
                if (cfg_valid) begin
                    case (cfg_index)
                        prl_pkg::REG_POLICY_MODE: policy_next = cfg_data[0];
                        prl_pkg::REG_LARGE_PAGES: begin
                            large_next = cfg_data[0];
                            used_next  = '0;
                        end
                        prl_pkg::REG_MEMORY_MB: begin
                            mb_next   = cfg_data;
                            used_next = '0;
                        end
                        default: ;
                    endcase
                end else if (s_tvalid) begin
                    page_next = page_in;
                    wr_next   = s_tuser;
                    n_next    = (n_raw > MAX_FRAMES_W) ? CNT_W'(MAX_FRAMES) : CNT_W'(n_raw);
                    rem_next  = '0;
                    bit_next  = BIT_W'(prl_pkg::STAMP_W - 1);
                    if (policy_reg == prl_pkg::POLICY_NRU) begin
                        state_next = prl_pkg::ST_MOD;
                    end else begin
                        state_next = prl_pkg::ST_PM_READ;
                    end
                end
            end
            prl_pkg::ST_MOD: begin
                rem_next = (mod_t >= {1'b0, n_reg}) ? CNT_W'(mod_t - {1'b0, n_reg})
                                                    : CNT_W'(mod_t);
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    idx_next = '0;
                    if ((rem_next == '0) && (used_reg != '0)) begin
                        state_next = prl_pkg::ST_CLEAR;
                    end else begin
                        state_next = prl_pkg::ST_PM_READ;
                    end
                end
            end
            prl_pkg::ST_CLEAR: begin
                idx_next = idx_reg + 1'b1;
                if (CNT_W'(idx_reg) == used_reg - 1'b1) begin
                    state_next = prl_pkg::ST_PM_READ;
                end
            end
            prl_pkg::ST_PM_READ: begin
                state_next = prl_pkg::ST_FR_READ;
            end
            prl_pkg::ST_FR_READ: begin
                frame_next = pm_rdata;
                state_next = prl_pkg::ST_HIT_CHECK;
            end
            prl_pkg::ST_HIT_CHECK: begin
                old_dirty_next = fr_dirty;
                ev_next        = 1'b0;
                wb_next        = 1'b0;
                evpage_next    = '0;
                if (hit) begin
                    fault_next = 1'b0;
                    state_next = prl_pkg::ST_UPDATE;
                end else begin
                    fault_next = 1'b1;
                    if (used_reg < n_reg) begin
                        frame_next = FRAME_W'(used_reg);
                        used_next  = used_reg + 1'b1;
                        state_next = prl_pkg::ST_UPDATE;
                    end else begin
                        idx_next        = '0;
                        cmp_valid_next  = 1'b0;
                        best_class_next = prl_pkg::CLASS_NONE;
                        state_next      = prl_pkg::ST_SCAN;
                    end
                end
            end
            prl_pkg::ST_SCAN: begin
                cmp_idx_next   = idx_reg;
                cmp_valid_next = 1'b1;
                if (CNT_W'(idx_reg) == n_reg - 1'b1) begin
                    state_next = prl_pkg::ST_SCAN_LAST;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            prl_pkg::ST_SCAN_LAST: begin
                cmp_valid_next = 1'b0;
                frame_next     = best_idx_next;
                evpage_next    = best_owner_next;
                wb_next        = best_dirty_next;
                ev_next        = 1'b1;
                state_next     = prl_pkg::ST_UPDATE;
            end
            prl_pkg::ST_UPDATE: begin
                if (upd_go) begin
                    clock_next = clock_reg + 1'b1;
                    if (fault_reg && (ftally_reg != TALLY_MAX)) begin
                        ftally_next = ftally_reg + 1'b1;
                    end
                    if (wb_reg && (wtally_reg != TALLY_MAX)) begin
                        wtally_next = wtally_reg + 1'b1;
                    end
                    out_valid_next = 1'b1;
                    o_fault_next   = fault_reg;
                    o_wb_next      = wb_reg;
                    o_ev_next      = ev_reg;
                    o_frame_next   = frame_reg;
                    o_evpage_next  = evpage_reg;
                    state_next     = prl_pkg::ST_IDLE;
                end
            end
            default: state_next = prl_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {o_ev_reg, o_wb_reg, o_fault_reg};
    assign m_tdata  = {{PAD_W{1'b0}}, wtally_reg, ftally_reg,
                       prl_pkg::EVPAGE_W'(o_evpage_reg),
                       prl_pkg::FRAME_OUT_W'(o_frame_reg)};

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, used_reg} <= MAX_FRAMES_C)
        else $error("frames in use exceed the frame limit");

    a_wb_le_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        wtally_reg <= ftally_reg)
        else $error("writeback count exceeds fault count");

    a_wb_needs_ev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[2] && m_tuser[0])
        else $error("writeback reported without an eviction");

    a_scan_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prl_pkg::ST_SCAN) |-> (used_reg == n_reg))
        else $error("victim scan started with free frames left");

    a_result_step: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_go |=> m_tvalid && (clock_reg == $past(clock_reg) + 1'b1))
        else $error("result not presented after update");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU/NRU page replacement core.
// ----------------------------------------------------------------------------
// Accesses are queued by a stimulus process and driven by a clocked driver.
// A behavioral page table predicts each result when an access transaction is
// accepted, and a clocked monitor compares every result transaction with the
// oldest prediction. The run goes through several policy and geometry
// settings and several idling phases on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [23:0] address;
        logic        is_write;
    } access_t;

    typedef struct packed {
        logic        fault;
        logic        writeback;
        logic [8:0]  frame;
        logic        evicted_valid;
        logic [10:0] evicted_page;
        logic [31:0] fault_total;
        logic [31:0] writeback_total;
    } outcome_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [prl_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_taken = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [prl_pkg::M_DATA_W-1:0] m_tdata;
    logic [prl_pkg::M_USER_W-1:0] m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [prl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [prl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    page_replacement_lru_nru_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Model state.
    logic        pol_nru;
    logic        pg_large;
    logic [2:0]  mem_mb;
    logic [15:0] pmap [0:2047];
    logic [10:0] owner [0:511];
    logic [31:0] stamp [0:511];
    logic        refd [0:511];
    logic        dirty [0:511];
    int unsigned used_frames;
    logic [31:0] clk_count;
    logic [31:0] faults;
    logic [31:0] writebacks;

    access_t  pending_accesses[$];
    outcome_t expected_outcomes[$];
    int       errors = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       watchdog = 0;

    task automatic flush_table();
        for (int i = 0; i < 2048; i++) pmap[i] = '0;
        for (int i = 0; i < 512; i++) begin
            refd[i] = 1'b0;
            dirty[i] = 1'b0;
        end
        used_frames = 0;
    endtask

    function automatic int unsigned frames_total();
        int unsigned mb;
        int unsigned n;
        mb = (mem_mb == 0) ? 1 : 32'(mem_mb);
        n = (mb * 1024) / (pg_large ? 16 : 8);
        return (n > 512) ? 512 : n;
    endfunction

    task automatic predict_access(input access_t a);
        outcome_t    o;
        int unsigned n;
        int unsigned pg;
        int unsigned fr;
        int unsigned best;
        int unsigned best_cls;
        int unsigned cls;
        o = '0;
        pg = 32'((a.address >> (pg_large ? prl_pkg::LARGE_SHIFT : prl_pkg::SMALL_SHIFT))
                 & 24'h0007ff);
        n = frames_total();
        if (pol_nru && (clk_count % n) == 0)
            for (int i = 0; i < used_frames; i++) refd[i] = 1'b0;
        if (pmap[pg][15]) begin
            fr = 32'(pmap[pg][8:0]);
        end else begin
            o.fault = 1'b1;
            if (faults != 32'hffffffff) faults++;
            if (used_frames < n) begin
                fr = used_frames;
                used_frames++;
            end else begin
                best = 0;
                best_cls = 4;
                for (int i = 0; i < n; i++) begin
                    cls = pol_nru ? 32'({refd[i], dirty[i]}) : 0;
                    if (cls < best_cls || (cls == best_cls && stamp[i] < stamp[best])) begin
                        best = i;
                        best_cls = cls;
                    end
                end
                fr = best;
                o.evicted_valid = 1'b1;
                o.evicted_page = owner[fr];
                if (dirty[fr]) begin
                    o.writeback = 1'b1;
                    if (writebacks != 32'hffffffff) writebacks++;
                end
                pmap[owner[fr]] = '0;
                dirty[fr] = 1'b0;
            end
            owner[fr] = pg[10:0];
            pmap[pg] = 16'h8000 | fr[15:0];
        end
        refd[fr] = 1'b1;
        stamp[fr] = clk_count;
        if (a.is_write) dirty[fr] = 1'b1;
        clk_count++;
        o.frame = fr[8:0];
        o.fault_total = faults;
        o.writeback_total = writebacks;
        expected_outcomes.push_back(o);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Driver.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_taken) begin
                if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_accesses[0].address;
                    s_tuser <= pending_accesses[0].is_write;
                    pending_accesses.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor and predictor.
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (aresetn) begin
            s_taken <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                watchdog <= 0;
            end else begin
                watchdog <= watchdog + 1;
            end
            if (s_tvalid && s_tready) begin
                predict_access({s_tdata, s_tuser});
            end
            if (m_tvalid && m_tready) begin
                got.frame = m_tdata[8:0];
                got.evicted_page = m_tdata[19:9];
                got.fault_total = m_tdata[51:20];
                got.writeback_total = m_tdata[83:52];
                got.fault = m_tuser[0];
                got.writeback = m_tuser[1];
                got.evicted_valid = m_tuser[2];
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 0);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got.fault !== want.fault)
                        report_mismatch("fault", got.fault, want.fault);
                    if (got.writeback !== want.writeback)
                        report_mismatch("writeback", got.writeback, want.writeback);
                    if (got.frame !== want.frame)
                        report_mismatch("frame", got.frame, want.frame);
                    if (got.evicted_valid !== want.evicted_valid)
                        report_mismatch("evicted_valid", got.evicted_valid, want.evicted_valid);
                    if (got.evicted_page !== want.evicted_page)
                        report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
                    if (got.fault_total !== want.fault_total)
                        report_mismatch("fault_total", got.fault_total, want.fault_total);
                    if (got.writeback_total !== want.writeback_total)
                        report_mismatch("writeback_total", got.writeback_total,
                                        want.writeback_total);
                end
            end
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_accesses.size() > 0 || s_tvalid || expected_outcomes.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_register(input logic [prl_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [prl_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == prl_pkg::REG_POLICY_MODE) begin
            pol_nru = val[0];
        end else if (idx == prl_pkg::REG_LARGE_PAGES) begin
            pg_large = val[0];
            flush_table();
        end else if (idx == prl_pkg::REG_MEMORY_MB) begin
            mem_mb = val;
            flush_table();
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Accesses drawn from a small working set so hits and evictions both occur.
    task automatic queue_accesses(input int count, input int pages);
        access_t a;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0) a.address = 24'($urandom);
            else a.address = 24'(($urandom_range(pages - 1) << 14) | $urandom_range(16383));
            a.is_write = 1'($urandom_range(1));
            pending_accesses.push_back(a);
        end
    endtask

    initial begin
        access_t a;
        pol_nru = prl_pkg::POLICY_LRU;
        pg_large = 1'b0;
        mem_mb = prl_pkg::MEMORY_MB_RESET;
        flush_table();
        for (int i = 0; i < 512; i++) begin
            owner[i] = '0;
            stamp[i] = '0;
        end
        clk_count = 0;
        faults = 0;
        writebacks = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: address extremes, reads and writes, hit after miss.
        a = '{24'h000000, 1'b0}; pending_accesses.push_back(a);
        a = '{24'hffffff, 1'b1}; pending_accesses.push_back(a);
        a = '{24'h000001, 1'b1}; pending_accesses.push_back(a);
        a = '{24'hffffff, 1'b0}; pending_accesses.push_back(a);
        a = '{24'haaaaaa, 1'b0}; pending_accesses.push_back(a);
        a = '{24'h555555, 1'b1}; pending_accesses.push_back(a);
        wait_drained();

        // Smallest memory with large pages: 64 frames, evictions under both policies.
        write_register(prl_pkg::REG_MEMORY_MB, 3'd1);
        write_register(prl_pkg::REG_LARGE_PAGES, 3'd1);
        queue_accesses(90, 80);
        wait_drained();
        write_register(prl_pkg::REG_POLICY_MODE, 3'(prl_pkg::POLICY_NRU));
        send_idle_pct = 46;
        queue_accesses(90, 80);
        wait_drained();

        // Zero memory size acts as one megabyte, small pages give 128 frames.
        write_register(prl_pkg::REG_LARGE_PAGES, 3'd0);
        write_register(prl_pkg::REG_MEMORY_MB, 3'd0);
        send_idle_pct = 0;
        recv_stall_pct = 46;
        queue_accesses(90, 80);
        wait_drained();

        // Too many frames saturate at the maximum.
        write_register(prl_pkg::REG_MEMORY_MB, 3'd7);
        send_idle_pct = 18;
        recv_stall_pct = 18;
        queue_accesses(120, 300);
        wait_drained();

        write_register(prl_pkg::REG_POLICY_MODE, 3'(prl_pkg::POLICY_LRU));
        write_register(prl_pkg::REG_MEMORY_MB, 3'd2);
        write_register(REG_UNMAPPED, 3'd5);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_accesses(154, 150);
        wait_drained();

        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/prl_pkg.sv
rtl/prl_ram.sv
rtl/page_replacement_lru_nru_core.sv
bench/tb_top.sv
